// ===== rtl/core/nrmc_pkg.sv =====
package nrmc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned HEADER_LEN = 6;

  localparam int unsigned CAPTURE_LIMIT_DEFAULT = 75;

  localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  localparam logic [BYTE_W-1:0] TYPE_ONE_RESET = 8'd77;  // 'M'
  localparam logic [BYTE_W-1:0] TYPE_TWO_RESET = 8'd67;  // 'C'

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_ONE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_TWO = 8'd1;

  typedef struct packed {
    logic              byte_kept;
    logic [POS_W-1:0]  keep_position;
    logic [BYTE_W-1:0] kept_value;
    logic              sentence_done;
    logic [POS_W-1:0]  sentence_length;
  } res_t;

endpackage

// ===== rtl/core/nmea_rmc_sentence_capture.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   rx_byte_i
// out       output     out_valid_o / out_stall_i byte_kept_o, keep_position_o, kept_value_o,
//                                                sentence_done_o, sentence_length_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction in gives exactly one transaction out. A byte is accepted
// into the input register, is filtered on its way into the result register,
// and is offered from there; one byte per cycle is sustained while out_stall_i
// is low. Reset (rst_ni low, async) empties both stages, clears the fill count
// and header store and restores the type letters to 'M','C'.
// Out stall holds the result register; the input register then keeps its
// byte and in_stall_o rises once it is occupied. cfg writes are always taken.
module nmea_rmc_sentence_capture
  import nrmc_pkg::*;
#(
  parameter int unsigned CaptureLimit = CAPTURE_LIMIT_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 byte_kept_o,
  output logic [POS_W-1:0]     keep_position_o,
  output logic [BYTE_W-1:0]    kept_value_o,
  output logic                 sentence_done_o,
  output logic [POS_W-1:0]     sentence_length_o,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_ready;
  logic              step;
  logic              in_fire;
  res_t              res_comb, res_reg;

  // Byte moves from the input register into the result register
  assign step       = s1_valid && out_ready;
  assign in_stall_o = s1_valid && !out_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  nrmc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .drain_i (step),
    .byte_i  (rx_byte_i),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  // Fill count, header store and type letters live here; the fill count and header
  // store advance only on the cycle a byte is handed to the result register.
  nrmc_filter #(
    .CaptureLimit (CaptureLimit)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (s1_byte),
    .res_o       (res_comb)
  );

  nrmc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .stall_i (out_stall_i),
    .res_i   (res_comb),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .res_o   (res_reg)
  );

  assign byte_kept_o       = res_reg.byte_kept;
  assign keep_position_o   = res_reg.keep_position;
  assign kept_value_o      = res_reg.kept_value;
  assign sentence_done_o   = res_reg.sentence_done;
  assign sentence_length_o = res_reg.sentence_length;

endmodule

// ===== rtl/core/nrmc_in_stage.sv =====
module nrmc_in_stage
  import nrmc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              drain_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              valid_o,
  output logic [BYTE_W-1:0] byte_o
);

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/core/nrmc_filter.sv =====
module nrmc_filter
  import nrmc_pkg::*;
#(
  parameter int unsigned CaptureLimit = CAPTURE_LIMIT_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 step_i,
  input  logic [BYTE_W-1:0]    byte_i,
  output res_t                 res_o
);

  // the incremented count reaches CaptureLimit+1 for one moment before saturating
  localparam int unsigned CntW  = $clog2(CaptureLimit + 2);
  localparam int unsigned HdrIdxW = $clog2(HEADER_LEN);

  localparam logic [CntW-1:0] Limit  = CntW'(CaptureLimit);
  localparam logic [CntW-1:0] HdrLen = CntW'(HEADER_LEN);

  logic [BYTE_W-1:0] type_one_q, type_two_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [BYTE_W-1:0] hdr_q [HEADER_LEN];
  logic [BYTE_W-1:0] hdr_d [HEADER_LEN];

  logic [CntW-1:0]   cnt_base, cnt_inc;
  logic              match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_one_q <= TYPE_ONE_RESET;
      type_two_q <= TYPE_TWO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TYPE_ONE: type_one_q <= cfg_data_i;
        CFG_TYPE_TWO: type_two_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cnt_base = (byte_i == CH_DOLLAR) ? '0 : cnt_q;
  assign cnt_inc  = cnt_base + CntW'(1);
  assign match    = (hdr_q[0] == CH_DOLLAR) && (hdr_q[4] == type_one_q) &&
                    (hdr_q[5] == type_two_q);

  always_comb begin
    cnt_d = cnt_base;
    hdr_d = hdr_q;
    res_o = '0;
    if (cnt_base < HdrLen) begin
      hdr_d[cnt_base[HdrIdxW-1:0]] = byte_i;
      cnt_d                  = cnt_inc;
      res_o.byte_kept        = 1'b1;
      res_o.keep_position    = POS_W'(cnt_base);
      res_o.kept_value       = byte_i;
    end else if (match) begin
      res_o.byte_kept     = 1'b1;
      res_o.keep_position = POS_W'(cnt_base);
      res_o.kept_value    = byte_i;
      if (byte_i == CH_NEWLINE) begin
        res_o.sentence_done   = 1'b1;
        res_o.sentence_length = POS_W'(cnt_inc);
        cnt_d = '0;
        for (int i = 0; i < HEADER_LEN; i++) begin
          hdr_d[i] = '0;
        end
      end else if (cnt_inc >= Limit) begin
        cnt_d = Limit;
        // overflow slot gets the zero terminator
        if (cnt_base == Limit) begin
          res_o.kept_value = '0;
        end
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < HEADER_LEN; i++) begin
        hdr_q[i] <= '0;
      end
    end else if (step_i) begin
      cnt_q <= cnt_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

// ===== rtl/core/nrmc_out_stage.sv =====
module nrmc_out_stage
  import nrmc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic stall_i,
  input  res_t res_i,
  output logic ready_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== verif/nmea_rmc_capture_check.sv =====
`timescale 1ns / 1ps

module nmea_rmc_capture_check
  import nrmc_pkg::*;
#(
  parameter int unsigned CaptureLimit = CAPTURE_LIMIT_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 byte_kept_i,
  input  logic [POS_W-1:0]     keep_position_i,
  input  logic [BYTE_W-1:0]    kept_value_i,
  input  logic                 sentence_done_i,
  input  logic [POS_W-1:0]     sentence_length_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  output int unsigned          err_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          sentences_o
);

  // shadow copy of the block's state and registers
  logic [BYTE_W-1:0] letter_one;
  logic [BYTE_W-1:0] letter_two;
  int unsigned       line_fill;
  logic [BYTE_W-1:0] hdr [HEADER_LEN];

  res_t        capture_q [$];
  int unsigned err_cnt;
  int unsigned checked;
  int unsigned sentences;

  function automatic res_t capture_byte(input logic [BYTE_W-1:0] b);
    res_t        r;
    int unsigned at;
    r = '0;
    if (b == CH_DOLLAR) line_fill = 0;
    if (line_fill < HEADER_LEN) begin
      hdr[line_fill]  = b;
      r.byte_kept     = 1'b1;
      r.keep_position = line_fill[POS_W-1:0];
      r.kept_value    = b;
      line_fill++;
    end else if (hdr[0] == CH_DOLLAR && hdr[4] == letter_one && hdr[5] == letter_two) begin
      at              = line_fill;
      r.byte_kept     = 1'b1;
      r.keep_position = at[POS_W-1:0];
      r.kept_value    = b;
      line_fill++;
      if (b == CH_NEWLINE) begin
        r.sentence_done   = 1'b1;
        r.sentence_length = line_fill[POS_W-1:0];
        line_fill         = 0;
        foreach (hdr[i]) hdr[i] = '0;
      end
      // saturate; a write at the limit is replaced by the terminator
      if (line_fill >= CaptureLimit) begin
        line_fill = CaptureLimit;
        if (at == CaptureLimit) r.kept_value = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      letter_one = TYPE_ONE_RESET;
      letter_two = TYPE_TWO_RESET;
      line_fill  = 0;
      foreach (hdr[i]) hdr[i] = '0;
      capture_q.delete();
      err_cnt   = 0;
      checked   = 0;
      sentences = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TYPE_ONE: letter_one = cfg_data_i;
          CFG_TYPE_TWO: letter_two = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.byte_kept       = byte_kept_i;
        got.keep_position   = keep_position_i;
        got.kept_value      = kept_value_i;
        got.sentence_done   = sentence_done_i;
        got.sentence_length = sentence_length_i;
        if (capture_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] unexpected result: kept=%0d pos=%0d val=%h done=%0d len=%0d",
                     $realtime, got.byte_kept, got.keep_position, got.kept_value,
                     got.sentence_done, got.sentence_length);
        end else begin
          want = capture_q.pop_front();
          checked++;
          if (got.byte_kept !== want.byte_kept || got.keep_position !== want.keep_position ||
              got.kept_value !== want.kept_value ||
              got.sentence_done !== want.sentence_done ||
              got.sentence_length !== want.sentence_length) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("[%0t] mismatch on result %0d", $realtime, checked);
              $display("  expected kept=%0d pos=%0d val=%h done=%0d len=%0d",
                       want.byte_kept, want.keep_position, want.kept_value,
                       want.sentence_done, want.sentence_length);
              $display("  actual   kept=%0d pos=%0d val=%h done=%0d len=%0d",
                       got.byte_kept, got.keep_position, got.kept_value,
                       got.sentence_done, got.sentence_length);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = capture_byte(rx_byte_i);
        if (want.sentence_done) sentences++;
        capture_q.push_back(want);
      end
    end
    err_count_o <= err_cnt;
    pending_o   <= capture_q.size();
    checked_o   <= checked;
    sentences_o <= sentences;
  end

endmodule

// ===== verif/tb_nmea_rmc_sentence_capture.sv =====
`timescale 1ns / 1ps

module tb_nmea_rmc_sentence_capture;
  import nrmc_pkg::*;

  // worst case is roughly 2300 bytes, each behind the longest gap and stall run
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned BytesPerSet = 350;
  localparam int unsigned NumSets     = 5;

  // indexes with no register behind them; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [BYTE_W-1:0]    rx_byte     = '0;
  logic                 out_stall   = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [BYTE_W-1:0]    cfg_data    = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic                 cfg_ready;
  logic                 byte_kept;
  logic [POS_W-1:0]     keep_position;
  logic [BYTE_W-1:0]    kept_value;
  logic                 sentence_done;
  logic [POS_W-1:0]     sentence_length;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sentences;

  int unsigned       cycle_cnt  = 0;
  int unsigned       bytes_sent = 0;
  bit                quiet      = 1'b0;  // no idling on either side while set
  logic [BYTE_W-1:0] cur_one    = TYPE_ONE_RESET;
  logic [BYTE_W-1:0] cur_two    = TYPE_TWO_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  nmea_rmc_sentence_capture dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .byte_kept_o       (byte_kept),
    .keep_position_o   (keep_position),
    .kept_value_o      (kept_value),
    .sentence_done_o   (sentence_done),
    .sentence_length_o (sentence_length),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  // predicts each result and compares every output transaction
  nmea_rmc_capture_check u_capture_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .byte_kept_i       (byte_kept),
    .keep_position_i   (keep_position),
    .kept_value_i      (kept_value),
    .sentence_done_i   (sentence_done),
    .sentence_length_i (sentence_length),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .err_count_o       (err_count),
    .pending_o         (pending),
    .checked_o         (checked),
    .sentences_o       (sentences)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet)  return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random filler: never a line start or a line end
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_DOLLAR || b == CH_NEWLINE) b = 8'h2C;
    return b;
  endfunction

  // one input transaction; payload held while stalled
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // let every expected result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // '$' + talker + type letters + body + newline; broken lines get a wrong
  // type letter. Some bodies run past the capture limit, some lines are cut.
  task automatic send_line(input bit matched);
    int unsigned       body;
    int unsigned       r;
    logic [BYTE_W-1:0] l1;
    logic [BYTE_W-1:0] l2;
    l1 = cur_one;
    l2 = cur_two;
    if (!matched) begin
      if ($urandom_range(0, 1)) l1 = cur_one ^ 8'($urandom_range(1, 255));
      else                      l2 = cur_two ^ 8'($urandom_range(1, 255));
    end
    r = $urandom_range(0, 99);
    if (r < 70)      body = $urandom_range(0, 20);
    else if (r < 85) body = $urandom_range(21, 60);
    else             body = $urandom_range(66, 85);
    send_byte(CH_DOLLAR);
    repeat (3) send_byte(plain_byte());
    send_byte(l1);
    send_byte(l2);
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 99) < 97) send_byte(plain_byte());
      else                            send_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) != 0) send_byte(CH_NEWLINE);
  endtask

  // output side: random stall runs in every phase but the quiet last one
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int unsigned r;
    int unsigned target;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset letters 'M','C':
    // a short matched sentence, extreme bytes with a newline in the header,
    // a line with a wrong type letter whose tail is dropped, and a sentence
    // ending right after the header
    send_text("$GPRMC,A\n");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_NEWLINE);
    send_text("$GNRMXZ\n");
    send_text("$ABCMC\n");
    drain_results();

    // random phases, each behind a fresh letter setting written while idle.
    // Every phase boundary doubles as a full hold-off of the sender.
    for (int unsigned p = 1; p <= NumSets; p++) begin
      case (p)
        1: begin cur_one = 8'h47; cur_two = 8'h41; end  // 'G','A'
        2: begin cur_one = 8'h00; cur_two = 8'hFF; end
        3: begin cur_one = 8'hFF; cur_two = 8'h00; end
        4: begin
          cur_one = 8'($urandom_range(0, 255));
          cur_two = 8'($urandom_range(0, 255));
        end
        default: begin cur_one = TYPE_ONE_RESET; cur_two = TYPE_TWO_RESET; end
      endcase
      write_reg(CFG_TYPE_ONE, cur_one);
      write_reg(CFG_TYPE_TWO, cur_two);
      if (p == 2) write_reg(CFG_UNUSED_LO, 8'($urandom_range(0, 255)));
      if (p == 4) write_reg(CFG_UNUSED_HI, 8'($urandom_range(0, 255)));
      quiet  = (p == NumSets);  // last phase runs back to back
      target = bytes_sent + BytesPerSet;
      while (bytes_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 75)      send_line(1'b1);
        else if (r < 88) send_line(1'b0);
        else             repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    $display("Sent %0d bytes under six type-letter settings, with ignored register writes",
             bytes_sent);
    $display("Compared %0d results, %0d of them finished sentences", checked, sentences);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
